>>> design/wmr_pkg.sv
`timescale 1ns / 1ps

package wmr_pkg;

    localparam int LANE_W     = 3;
    localparam int SAMPLE_W   = 64;
    localparam int RAW_W      = 32;
    localparam int GEN_W      = 32;
    localparam int MASK_W     = 8;
    localparam int CNT_W      = 32;

    localparam int SUM_W      = 128;
    localparam int SQ_W       = 128;
    localparam int RSUM_W     = 64;
    localparam int RSQ_W      = 96;

    localparam int MUL_AW     = 128;
    localparam int MUL_BW     = 64;
    localparam int MUL_PW     = MUL_AW + MUL_BW;
    localparam int DIV_W      = 128;
    localparam int ROOT_W     = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_REMOVE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd5;

    localparam logic [CNT_W-1:0]  WINDOW_SIZE_RESET = 32'd6400;
    localparam logic [MASK_W-1:0] LANE_MASK_LIMIT   = 8'h7F;

    typedef struct packed {
        logic [LANE_W-1:0]          lane;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [RAW_W-1:0]    raw;
        logic [GEN_W-1:0]           frame_gen;
        logic                       malformed;
        logic                       cycle_mode;
        logic                       close_mark;
        logic [MASK_W-1:0]          frame_mask;
    } item_t;

    typedef struct packed {
        logic [LANE_W-1:0]          out_lane;
        logic signed [SAMPLE_W-1:0] mean;
        logic [ROOT_W-1:0]          rms;
        logic [31:0]                rms_raw;
        logic [CNT_W-1:0]           window_count;
        logic [31:0]                seq_number;
        logic                       lane_valid;
        logic                       overflow;
        logic                       last;
    } result_t;

    // one accumulator memory word per lane
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sq;
        logic [RSUM_W-1:0] rsum;
        logic [RSQ_W-1:0]  rsq;
    } acc_t;

endpackage

>>> design/windowed_mean_rms_meter.sv
`timescale 1ns / 1ps

// Windowed mean and RMS meter. Lane requests arrive in frame order (lanes 0 to
// LANES-1); each accepted request is folded into that lane's accumulators (signed
// sum, saturating sum of squares, raw sum, raw square sum), which live in one
// single-port-read accumulator RAM as a read-modify-write. A request is accepted
// and its RAM word read, then the shared 32x32 multiplier squares the 64-bit
// sample, then the word is written back and the sequencer returns to idle.
// When the last lane's request closes the window, the block finalizes every lane
// in turn with a bit-serial 128-bit divider and a bit-serial square root (a
// divide for the mean, then a divide and a root per domain, plus multiplier
// passes), during which no new request is taken. Results then leave one per
// lane from a result buffer, and new requests are accepted while they drain; a
// later window close waits until the previous results are all taken.
// Configuration writes are always ready and are meant for idle periods only; any
// write to a known register clears the window and the sticky overflow flag. The
// sample rate register is not stored here.
module windowed_mean_rms_meter import wmr_pkg::*; #(
    parameter int LANES = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [LANE_W:0] LANE_LIM = (LANE_W+1)'(LANES);
    localparam logic [LW-1:0]   LAST_K   = LW'(LANES - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WAIT = 4'd1;   // wait for an arithmetic unit
    localparam logic [3:0] S_UPD  = 4'd2;   // accumulator write-back
    localparam logic [3:0] S_FWT  = 4'd3;   // wait for previous results to drain
    localparam logic [3:0] F_RD   = 4'd4;
    localparam logic [3:0] F_LD   = 4'd5;
    localparam logic [3:0] F_MN   = 4'd6;
    localparam logic [3:0] F_ME   = 4'd7;
    localparam logic [3:0] F_NR   = 4'd8;
    localparam logic [3:0] F_SR   = 4'd9;
    localparam logic [3:0] F_DV   = 4'd10;
    localparam logic [3:0] F_DR   = 4'd11;
    localparam logic [3:0] F_RR   = 4'd12;
    localparam logic [3:0] F_NEXT = 4'd13;

    // configuration
    logic [GEN_W-1:0]  generation_reg;
    logic [CNT_W-1:0]  window_size_reg;
    logic [MASK_W-1:0] lane_mask_reg;
    logic              enable_reg;
    logic              dc_remove_reg;

    // window control
    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [3:0]        ret_reg;
    logic [CNT_W-1:0]  frame_count_reg;
    logic              sticky_reg;
    logic              drop_reg;
    logic [31:0]       window_seq_reg;

    // request being accumulated
    item_t             item_reg;
    logic              fresh_reg;
    logic [63:0]       rawsq_reg;

    // finalize working set
    logic [LW-1:0]     fin_k_reg;
    logic              dom_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MASK_W-1:0] close_mask_reg;
    logic [SUM_W-1:0]  a_reg;
    logic              sn_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [RSQ_W-1:0]  rsq_reg;
    logic [RSUM_W-1:0] ra_reg;
    logic [127:0]      d_reg;
    logic [127:0]      num_reg;

    // result buffer and drain
    logic [63:0]       mean_buf [LANES];
    logic [63:0]       rms_buf  [LANES];
    logic [31:0]       raw_buf  [LANES];
    logic              emit_busy_reg;
    logic [LW-1:0]     emit_k_reg;
    logic [CNT_W-1:0]  emit_cnt_reg;
    logic [MASK_W-1:0] emit_mask_reg;
    logic              emit_ov_reg;

    // accumulator ram
    logic              ram_we;
    logic              ram_re;
    logic [LW-1:0]     ram_raddr;
    acc_t              ram_rdata;
    acc_t              ram_wdata;
    acc_t              base;

    // arithmetic units
    logic              mul_start;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic              mul_done;
    logic [MUL_PW-1:0] mul_prod;
    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic [DIV_W-1:0]  div_den;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    // request decode
    logic              accept;
    logic              lane_ok;
    logic              drop_eff;
    logic              reject;
    logic              take;
    logic [63:0]       smp_u;
    logic [63:0]       mag_in;
    logic [31:0]       raw_u;
    logic [31:0]       rm_in;

    // write-back and finalize helpers
    logic [SQ_W:0]     sq_sum;
    logic [CNT_W-1:0]  cnt_now;
    logic              closes;
    logic              s_hi_zero;
    logic [63:0]       s_lo;
    logic              num_top;
    logic [127:0]      num_clamp;
    logic [SUM_W-1:0]  ld_a;
    logic [RSUM_W-1:0] ld_ra;
    logic [63:0]       mean_q;
    logic              cfg_we;
    logic              cfg_known;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign lane_ok    = enable_reg && ({1'b0, item.lane} < LANE_LIM);
    assign drop_eff   = (item.lane != '0) && drop_reg;
    assign reject     = item.malformed || (item.frame_gen != generation_reg);
    assign take       = accept && lane_ok && !drop_eff && !reject;

    assign smp_u  = item.sample;
    assign mag_in = smp_u[63] ? (64'd0 - smp_u) : smp_u;
    assign raw_u  = item.raw;
    assign rm_in  = raw_u[31] ? (32'd0 - raw_u) : raw_u;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index)
            CFG_GENERATION, CFG_WINDOW_SIZE, CFG_LANE_MASK,
            CFG_ENABLE, CFG_DC_REMOVE, CFG_SAMPLE_RATE: cfg_known = 1'b1;
            default:                                    cfg_known = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // accumulator memory, one word per lane
    // ------------------------------------------------------------------
    assign ram_re    = take || (state_reg == F_RD);
    assign ram_raddr = (state_reg == F_RD) ? fin_k_reg : item.lane[LW-1:0];
    assign ram_we    = (state_reg == S_UPD);

    wmr_ram #(
        .WIDTH ($bits(acc_t)),
        .DEPTH (LANES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.lane[LW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first frame of a window starts from zero
    assign base   = fresh_reg ? '0 : ram_rdata;
    assign sq_sum = {1'b0, base.sq} + {1'b0, mul_prod[SQ_W-1:0]};

    always_comb
    begin
        ram_wdata.sum  = base.sum + {{(SUM_W-SAMPLE_W){item_reg.sample[SAMPLE_W-1]}},
                                     item_reg.sample};
        ram_wdata.sq   = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
        ram_wdata.rsum = base.rsum + {{(RSUM_W-RAW_W){item_reg.raw[RAW_W-1]}},
                                      item_reg.raw};
        ram_wdata.rsq  = base.rsq + {{(RSQ_W-64){1'b0}}, rawsq_reg};
    end

    assign cnt_now = frame_count_reg + 32'd1;
    assign closes  = (item_reg.cycle_mode && item_reg.close_mark) ||
                     (!item_reg.cycle_mode && (window_size_reg != '0) &&
                      (cnt_now >= window_size_reg));

    // ------------------------------------------------------------------
    // finalize helpers
    // ------------------------------------------------------------------
    assign ld_a  = ram_rdata.sum[SUM_W-1] ? (128'd0 - ram_rdata.sum) : ram_rdata.sum;
    assign ld_ra = ram_rdata.rsum[RSUM_W-1] ? (64'd0 - ram_rdata.rsum) : ram_rdata.rsum;

    // raw domain sum always fits 64 bits
    assign s_hi_zero = dom_reg ? 1'b1 : (a_reg[127:64] == '0);
    assign s_lo      = dom_reg ? ra_reg : a_reg[63:0];

    // count times square sum beyond 128 bits clamps
    assign num_top   = (mul_prod[MUL_PW-1:128] != '0);
    assign num_clamp = num_top ? '1 : mul_prod[127:0];

    assign mean_q = sn_reg ? (64'd0 - div_quo[63:0]) : div_quo[63:0];

    // unit launches
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        priority if (take)
        begin
            mul_start = 1'b1;
            mul_a     = {64'd0, mag_in};
            mul_b     = mag_in;
        end
        else if ((state_reg == F_LD) && (cnt_reg != '0))
        begin
            mul_start = 1'b1;
            mul_a     = {96'd0, cnt_reg};
            mul_b     = {32'd0, cnt_reg};
        end
        else if (state_reg == F_ME)
        begin
            mul_start = 1'b1;
            mul_a     = sq_reg;
            mul_b     = {32'd0, cnt_reg};
        end
        else if ((state_reg == F_NR) && dc_remove_reg && s_hi_zero)
        begin
            mul_start = 1'b1;
            mul_a     = {64'd0, s_lo};
            mul_b     = s_lo;
        end
        else if ((state_reg == F_RR) && !dom_reg)
        begin
            mul_start = 1'b1;
            mul_a     = {32'd0, rsq_reg};
            mul_b     = {32'd0, cnt_reg};
        end
        else
        begin
            mul_start = 1'b0;
        end
    end

    assign div_start  = (state_reg == F_MN) || (state_reg == F_DV);
    assign div_num    = (state_reg == F_MN) ? a_reg : num_reg;
    assign div_den    = (state_reg == F_MN) ? {96'd0, cnt_reg} : d_reg;
    assign sqrt_start = (state_reg == F_DR);

    wmr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    wmr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    wmr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (div_quo),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (take) state_next = S_WAIT;
            S_WAIT: if (mul_done || div_done || sqrt_done) state_next = ret_reg;
            S_UPD:  state_next = ((item_reg.lane == LANE_W'(LANES - 1)) && closes) ?
                                 S_FWT : S_IDLE;
            S_FWT:  if (!emit_busy_reg) state_next = F_RD;
            F_RD:   state_next = F_LD;
            F_LD:   state_next = (cnt_reg == '0) ? F_NEXT : S_WAIT;
            F_MN:   state_next = S_WAIT;
            F_ME:   state_next = S_WAIT;
            F_NR:   state_next = (dc_remove_reg && s_hi_zero) ? S_WAIT : F_DV;
            F_SR:   state_next = F_DV;
            F_DV:   state_next = S_WAIT;
            F_DR:   state_next = S_WAIT;
            F_RR:   state_next = dom_reg ? F_NEXT : S_WAIT;
            F_NEXT: state_next = (fin_k_reg == LAST_K) ? S_IDLE : F_RD;
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            generation_reg  <= '0;
            window_size_reg <= WINDOW_SIZE_RESET;
            lane_mask_reg   <= '0;
            enable_reg      <= 1'b0;
            dc_remove_reg   <= 1'b1;
            frame_count_reg <= '0;
            sticky_reg      <= 1'b0;
            drop_reg        <= 1'b0;
            window_seq_reg  <= '0;
            fin_k_reg       <= '0;
            dom_reg         <= 1'b0;
            emit_busy_reg   <= 1'b0;
            emit_k_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // request intake: drop flag and rejected frames
            if (accept && lane_ok)
            begin
                if ((item.lane == '0) && !reject)
                begin
                    drop_reg <= 1'b0;
                end
                if (!drop_eff && reject)
                begin
                    drop_reg        <= 1'b1;
                    frame_count_reg <= '0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        ret_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (sq_sum[SQ_W])
                    begin
                        sticky_reg <= 1'b1;
                    end
                    if (item_reg.lane == LANE_W'(LANES - 1))
                    begin
                        frame_count_reg <= closes ? '0 : cnt_now;
                    end
                end
                S_FWT:
                begin
                    fin_k_reg <= '0;
                end
                F_LD:
                begin
                    if (cnt_reg == '0)
                    begin
                        sticky_reg <= 1'b1;
                    end
                    else
                    begin
                        ret_reg <= F_MN;
                    end
                end
                F_MN:
                begin
                    ret_reg <= F_ME;
                end
                F_ME:
                begin
                    dom_reg <= 1'b0;
                    ret_reg <= F_NR;
                end
                F_NR:
                begin
                    if (num_top || (dc_remove_reg && !s_hi_zero))
                    begin
                        sticky_reg <= 1'b1;
                    end
                    ret_reg <= F_SR;
                end
                F_SR:
                begin
                    if (num_reg < mul_prod[127:0])
                    begin
                        sticky_reg <= 1'b1;
                    end
                end
                F_DV:
                begin
                    ret_reg <= F_DR;
                end
                F_DR:
                begin
                    ret_reg <= F_RR;
                end
                F_RR:
                begin
                    if (!dom_reg)
                    begin
                        dom_reg <= 1'b1;
                        ret_reg <= F_NR;
                    end
                end
                F_NEXT:
                begin
                    if (fin_k_reg == LAST_K)
                    begin
                        window_seq_reg <= window_seq_reg + 32'd1;
                    end
                    else
                    begin
                        fin_k_reg <= fin_k_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // result drain
            if ((state_reg == F_NEXT) && (fin_k_reg == LAST_K))
            begin
                emit_busy_reg <= 1'b1;
                emit_k_reg    <= '0;
            end
            else if (emit_busy_reg && !result_stall)
            begin
                if (emit_k_reg == LAST_K)
                begin
                    emit_busy_reg <= 1'b0;
                end
                else
                begin
                    emit_k_reg <= emit_k_reg + 1'b1;
                end
            end

            // configuration writes are to come only while idle (the block does not enforce this) and win over the rest
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GENERATION:  generation_reg  <= cfg_data;
                    CFG_WINDOW_SIZE: window_size_reg <= cfg_data;
                    CFG_LANE_MASK:   lane_mask_reg   <= cfg_data[MASK_W-1:0];
                    CFG_ENABLE:      enable_reg      <= cfg_data[0];
                    CFG_DC_REMOVE:   dc_remove_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
                if (cfg_known)
                begin
                    frame_count_reg <= '0;
                    sticky_reg      <= 1'b0;
                    drop_reg        <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg  <= item;
            fresh_reg <= (frame_count_reg == '0);
            rawsq_reg <= rm_in * rm_in;
        end

        if ((state_reg == S_UPD) && closes)
        begin
            cnt_reg        <= cnt_now;
            close_mask_reg <= lane_mask_reg & item_reg.frame_mask & LANE_MASK_LIMIT;
        end

        unique case (state_reg)
            F_LD:
            begin
                a_reg   <= ld_a;
                sn_reg  <= ram_rdata.sum[SUM_W-1];
                sq_reg  <= ram_rdata.sq;
                rsq_reg <= ram_rdata.rsq;
                ra_reg  <= ld_ra;
                if (cnt_reg == '0)
                begin
                    mean_buf[fin_k_reg] <= '0;
                    rms_buf[fin_k_reg]  <= '0;
                    raw_buf[fin_k_reg]  <= '0;
                end
            end
            F_MN:
            begin
                d_reg <= mul_prod[127:0];
            end
            F_ME:
            begin
                mean_buf[fin_k_reg] <= mean_q;
            end
            F_NR:
            begin
                num_reg <= (dc_remove_reg && !s_hi_zero) ? '0 : num_clamp;
            end
            F_SR:
            begin
                num_reg <= (num_reg >= mul_prod[127:0]) ? (num_reg - mul_prod[127:0]) : '0;
            end
            F_RR:
            begin
                if (dom_reg)
                begin
                    raw_buf[fin_k_reg] <= sqrt_root[31:0];
                end
                else
                begin
                    rms_buf[fin_k_reg] <= sqrt_root;
                end
            end
            default:
            begin
            end
        endcase

        // window facts travel with the drained results
        if ((state_reg == F_NEXT) && (fin_k_reg == LAST_K))
        begin
            emit_cnt_reg  <= cnt_reg;
            emit_mask_reg <= close_mask_reg;
            emit_ov_reg   <= sticky_reg;
        end
    end

    // ------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------
    assign result_valid = emit_busy_reg;

    always_comb
    begin
        result.out_lane     = LANE_W'(emit_k_reg);
        result.mean         = mean_buf[emit_k_reg];
        result.rms          = rms_buf[emit_k_reg];
        result.rms_raw      = raw_buf[emit_k_reg];
        result.window_count = emit_cnt_reg;
        result.seq_number   = window_seq_reg;
        result.lane_valid   = emit_mask_reg[emit_k_reg];
        result.overflow     = emit_ov_reg;
        result.last         = (emit_k_reg == LAST_K);
    end

endmodule

>>> design/wmr_ram.sv
`timescale 1ns / 1ps

module wmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/wmr_mul.sv
`timescale 1ns / 1ps

// 128 x 64 product from eight 32 x 32 partial products, one per cycle
module wmr_mul import wmr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic              done,
    output logic [MUL_PW-1:0] prod
);

    logic [MUL_AW-1:0] a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MUL_PW-1:0] prod_reg;
    logic [2:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [63:0]       pp;
    logic [2:0]        wsh;
    logic [MUL_PW-1:0] pp_shifted;

    assign pp         = a_reg[step_reg[2:1]*32 +: 32] * b_reg[step_reg[0]*32 +: 32];
    assign wsh        = {1'b0, step_reg[2:1]} + {2'b00, step_reg[0]};
    assign pp_shifted = {{(MUL_PW-64){1'b0}}, pp} << {wsh, 5'b00000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

>>> design/wmr_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module wmr_div import wmr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [DIV_W-1:0] quo
);

    logic [DIV_W-1:0] n_reg;
    logic [DIV_W-1:0] d_reg;
    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   r2;
    logic [DIV_W+1:0] diff;
    logic             ge;

    assign r2   = {rem_reg[DIV_W-1:0], n_reg[DIV_W-1]};
    assign diff = {1'b0, r2} - {2'b00, d_reg};
    assign ge   = !diff[DIV_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            d_reg   <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[DIV_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DIV_W:0] : r2;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> design/wmr_sqrt.sv
`timescale 1ns / 1ps

// digit-by-digit floor square root, one root bit per cycle
module wmr_sqrt import wmr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  rad,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 4;

    logic [DIV_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  r2;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;

    assign r2    = {rem_reg[REM_W-3:0], rad_reg[DIV_W-1:DIV_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = {1'b0, r2} - {1'b0, trial};
    assign ge    = !diff[REM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[DIV_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : r2;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> design/wmr_checker.sv
`timescale 1ns / 1ps

module wmr_checker import wmr_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

    // lanes of one window drain without gaps, in order, under one sequence number
    a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last) |=>
        (result_valid && (result.seq_number == $past(result.seq_number)) &&
         (result.out_lane == $past(result.out_lane) + 3'd1)))
        else $error("window results out of order");

    // a wrapped frame count yields cleared values and overflow
    a_wrap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.window_count == '0)) |->
        (result.overflow && (result.mean == '0) && (result.rms == '0)))
        else $error("wrapped window not cleared");

    // a window always starts at lane zero
    a_first_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last) |=>
        (!result_valid || (result.out_lane == '0)))
        else $error("window did not start at lane zero");

endmodule

bind windowed_mean_rms_meter wmr_checker u_wmr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

>>> tb/tb_windowed_mean_rms_meter.sv
`timescale 1ns / 1ps

module tb_windowed_mean_rms_meter;
    import wmr_pkg::*;

    localparam int LANES = 7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item_req = '0;
    // result side
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    // register write port
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    windowed_mean_rms_meter #(.LANES(LANES)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // stimulus and expectation stores
    item_t   pending_items[$];
    result_t expected_results[$];
    int      mismatches = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    logic    item_taken = 1'b0;
    logic    hold_on = 1'b0;
    event    hold_kick;

    // generator side copy of the generation tag, used to build matching frames
    logic [31:0] cur_gen = '0;

    // ---------------------------------------------------------------
    // predictor state: per-lane accumulators, window bookkeeping, registers
    // ---------------------------------------------------------------
    logic [127:0] lane_sum [LANES];
    logic [127:0] lane_sq  [LANES];
    logic [63:0]  lane_rsum[LANES];
    logic [95:0]  lane_rsq [LANES];
    logic [31:0]  frames_in_window = '0;
    logic         ovf_sticky = 1'b0;
    logic [31:0]  windows_closed = '0;
    logic         dropping = 1'b0;

    logic [31:0]  reg_generation = '0;
    logic [31:0]  reg_window_size = WINDOW_SIZE_RESET;
    logic [7:0]   reg_lane_mask = '0;
    logic         reg_enable = 1'b0;
    logic         reg_dc_remove = 1'b1;
    logic [31:0]  reg_sample_rate = 32'd32000;

    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] c2;
        res = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = res | (64'd1 << k);
            c2 = {64'd0, cand} * {64'd0, cand};
            if (c2 <= n)
                res = cand;
        end
        return res;
    endfunction

    // floor root of (N*sq - [dc]*s^2) / N^2, with the clamps that flag overflow
    function automatic logic [63:0] root_of_variance(logic [127:0] sq, logic [127:0] s,
                                                     logic [31:0] n);
        logic [191:0] prod;
        logic [127:0] num;
        logic [127:0] ss;
        logic [127:0] den;
        prod = {64'd0, sq} * {160'd0, n};
        num = prod[127:0];
        if (prod[191:128] != 0)
        begin
            ovf_sticky = 1'b1;
            num = '1;
        end
        if (reg_dc_remove)
        begin
            if (s[127:64] != 0)
            begin
                ovf_sticky = 1'b1;
                num = '0;
            end
            else
            begin
                ss = {64'd0, s[63:0]} * {64'd0, s[63:0]};
                if (num >= ss)
                    num = num - ss;
                else
                begin
                    num = '0;
                    ovf_sticky = 1'b1;
                end
            end
        end
        den = {96'd0, n} * {96'd0, n};
        return isqrt128(num / den);
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            CFG_GENERATION:  reg_generation = val;
            CFG_WINDOW_SIZE: reg_window_size = val;
            CFG_LANE_MASK:   reg_lane_mask = val[7:0];
            CFG_ENABLE:      reg_enable = val[0];
            CFG_DC_REMOVE:   reg_dc_remove = val[0];
            CFG_SAMPLE_RATE: reg_sample_rate = val;
            default:         return;
        endcase
        // any known register write restarts the window
        frames_in_window = '0;
        ovf_sticky = 1'b0;
        dropping = 1'b0;
    endfunction

    function automatic void predict_item(item_t it);
        logic         fresh;
        logic [63:0]  s;
        logic [63:0]  mag;
        logic [127:0] sqv;
        logic [127:0] base;
        logic [128:0] tsum;
        logic [63:0]  r64;
        logic [63:0]  rm;
        logic [31:0]  cnt_now;
        logic         closes;
        logic [127:0] a;
        logic [63:0]  ra;
        logic [7:0]   rmask;
        logic [63:0]  means[LANES];
        logic [63:0]  rmss[LANES];
        logic [63:0]  raws[LANES];
        result_t      res;
        int           l;

        l = it.lane;
        if (!reg_enable || l >= LANES)
            return;
        if (l == 0)
            dropping = 1'b0;
        if (dropping)
            return;
        if (it.malformed || it.frame_gen != reg_generation)
        begin
            frames_in_window = '0;
            dropping = 1'b1;
            return;
        end

        fresh = (frames_in_window == 0);
        s = it.sample;
        mag = s[63] ? -s : s;
        lane_sum[l] = (fresh ? 128'd0 : lane_sum[l]) + {{64{s[63]}}, s};
        sqv = {64'd0, mag} * {64'd0, mag};
        base = fresh ? 128'd0 : lane_sq[l];
        tsum = {1'b0, base} + {1'b0, sqv};
        if (tsum[128])
        begin
            lane_sq[l] = '1;
            ovf_sticky = 1'b1;
        end
        else
            lane_sq[l] = tsum[127:0];
        r64 = {{32{it.raw[31]}}, it.raw};
        lane_rsum[l] = (fresh ? 64'd0 : lane_rsum[l]) + r64;
        rm = r64[63] ? -r64 : r64;
        lane_rsq[l] = (fresh ? 96'd0 : lane_rsq[l]) + {32'd0, rm * rm};

        if (l != LANES - 1)
            return;

        cnt_now = frames_in_window + 32'd1;
        closes = (it.cycle_mode && it.close_mark) ||
                 (!it.cycle_mode && reg_window_size != 0 && cnt_now >= reg_window_size);
        if (!closes)
        begin
            frames_in_window = cnt_now;
            return;
        end
        frames_in_window = '0;

        rmask = reg_lane_mask & it.frame_mask & LANE_MASK_LIMIT;
        for (int k = 0; k < LANES; k++)
        begin
            a = lane_sum[k][127] ? -lane_sum[k] : lane_sum[k];
            ra = lane_rsum[k][63] ? -lane_rsum[k] : lane_rsum[k];
            if (cnt_now == 0)
            begin
                // frame counter wrapped: everything reads zero
                means[k] = '0;
                rmss[k] = '0;
                raws[k] = '0;
                ovf_sticky = 1'b1;
                continue;
            end
            mag = 64'(a / {96'd0, cnt_now});
            means[k] = lane_sum[k][127] ? -mag : mag;
            rmss[k] = root_of_variance(lane_sq[k], a, cnt_now);
            raws[k] = root_of_variance({32'd0, lane_rsq[k]}, {64'd0, ra}, cnt_now);
        end
        windows_closed = windows_closed + 32'd1;
        for (int k = 0; k < LANES; k++)
        begin
            res.out_lane = 3'(k);
            res.mean = means[k];
            res.rms = rmss[k];
            res.rms_raw = raws[k][31:0];
            res.window_count = cnt_now;
            res.seq_number = windows_closed;
            res.lane_valid = rmask[k];
            res.overflow = ovf_sticky;
            res.last = (k == LANES - 1);
            expected_results.push_back(res);
        end
    endfunction

    // ---------------------------------------------------------------
    // monitor: check results, then fold accepted requests and register writes
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        item_taken <= item_valid && !item_stall;
        if (result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.out_lane !== want.out_lane || result.mean !== want.mean ||
                    result.rms !== want.rms || result.rms_raw !== want.rms_raw ||
                    result.window_count !== want.window_count ||
                    result.seq_number !== want.seq_number ||
                    result.lane_valid !== want.lane_valid ||
                    result.overflow !== want.overflow || result.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", want, result);
                end
            end
        end
        if (item_valid && item_stall === 1'b0)
            predict_item(item_req);
        if (cfg_valid && cfg_ready === 1'b1)
            apply_reg_write(cfg_index, cfg_data);
    end

    // ---------------------------------------------------------------
    // driver: requests and receiver stall change on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!item_valid || item_taken)
        begin
            if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                item_req <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
        result_stall <= hold_on || ($urandom_range(99) < recv_idle);
    end

    // long receiver hold-off so finalized results back up into the input
    always
    begin
        @(hold_kick);
        hold_on <= 1'b1;
        repeat (6000) @(negedge clk);
        hold_on <= 1'b0;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued request went in and every result came back
    task automatic drain();
        wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_sample(bit extreme);
        logic [31:0] u;
        u = $urandom;
        if (extreme)
            return $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        case ($urandom_range(9))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return 64'd0;
            3:       return {$urandom, $urandom};
            default: return {{32{u[31]}}, u};
        endcase
    endfunction

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one frame of lane requests; style picks a clean frame or one of the
    // broken shapes (rejected lane, skipped lane, out-of-range lane thrown in)
    task automatic send_frame(bit cyc, bit mark, int style, bit extreme, output int n);
        item_t it;
        int    pick;
        logic [7:0] fmask;
        pick = $urandom_range(LANES - 1);
        fmask = 8'($urandom);
        n = 0;
        for (int l = 0; l < LANES; l++)
        begin
            if (style == 3 && l == pick)
            begin
                it = '0;
                it.lane = 3'd7;
                it.sample = pick_sample(0);
                it.raw = pick_raw();
                it.frame_gen = cur_gen;
                it.cycle_mode = cyc;
                it.close_mark = mark;
                it.frame_mask = fmask;
                pending_items.push_back(it);
            end
            if (style == 2 && l == pick)
                continue;
            it.lane = 3'(l);
            it.sample = pick_sample(extreme);
            it.raw = pick_raw();
            it.frame_gen = cur_gen;
            it.malformed = 1'b0;
            it.cycle_mode = cyc;
            it.close_mark = mark;
            it.frame_mask = fmask;
            if (style == 1 && l == pick)
            begin
                if ($urandom_range(1))
                    it.malformed = 1'b1;
                else
                    it.frame_gen = cur_gen ^ ($urandom | 32'd1);
            end
            pending_items.push_back(it);
            n++;
        end
    endtask

    task automatic run_random(int target);
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < target)
        begin
            r = $urandom_range(99);
            if (r < 5)
            begin
                // burst of full-scale frames to saturate the square sums
                for (int f = 0; f < 5; f++)
                begin
                    send_frame(1'b1, f == 4, 0, 1'b1, n);
                    sent += n;
                end
            end
            else
            begin
                send_frame($urandom_range(1), $urandom_range(2) == 0,
                           r < 15 ? 1 : r < 20 ? 2 : r < 25 ? 3 : 0, 1'b0, n);
                sent += n;
            end
        end
    endtask

    task automatic set_gen(logic [31:0] g);
        cur_gen = g;
        write_reg(CFG_GENERATION, g);
    endtask

    initial
    begin
        item_t it;
        int    n;
        logic [63:0] edge_samples[LANES];
        logic [31:0] edge_raws[LANES];

        edge_samples = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, '1,
                         64'd1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF};
        edge_raws = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, '1, 32'd1,
                      32'h8000_0000, 32'h7FFF_FFFF};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // first setting: every register written, widest sample rate
        send_idle = 7;
        recv_idle = 68;
        set_gen(32'hA5A5_0001);
        write_reg(CFG_WINDOW_SIZE, 32'd3);
        write_reg(CFG_LANE_MASK, 32'hFF);
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_DC_REMOVE, 32'd1);
        write_reg(CFG_SAMPLE_RATE, 32'hFFFF_FFFF);

        // two full frames of extreme values, closed by the close marker
        for (int f = 0; f < 2; f++)
            for (int l = 0; l < LANES; l++)
            begin
                it = '0;
                it.lane = 3'(l);
                it.sample = edge_samples[l];
                it.raw = edge_raws[l];
                it.frame_gen = cur_gen;
                it.cycle_mode = 1'b1;
                it.close_mark = (f == 1);
                it.frame_mask = (f == 1) ? 8'h55 : 8'hFF;
                pending_items.push_back(it);
            end
        // out-of-range lane, malformed frame with a dropped follower, stale tag
        it = '0;
        it.lane = 3'd7;
        it.frame_gen = cur_gen;
        pending_items.push_back(it);
        it.lane = 3'd0;
        it.malformed = 1'b1;
        pending_items.push_back(it);
        it.lane = 3'd1;
        it.malformed = 1'b0;
        pending_items.push_back(it);
        it.lane = 3'd0;
        it.frame_gen = ~cur_gen;
        pending_items.push_back(it);

        // receiver goes quiet while the sender keeps pushing
        ->hold_kick;
        run_random(80);
        drain();

        // second setting: cycle mode only, no lanes valid, plain RMS
        set_gen(32'd0);
        write_reg(CFG_WINDOW_SIZE, 32'd0);
        write_reg(CFG_LANE_MASK, 32'd0);
        write_reg(CFG_DC_REMOVE, 32'd0);
        write_reg(CFG_SAMPLE_RATE, 32'd0);
        run_random(40);
        drain();
        run_random(40);
        drain();

        // third setting: receiver mostly ready, sender idles a lot
        send_idle = 68;
        recv_idle = 7;
        set_gen(32'hFFFF_FFFF);
        write_reg(CFG_WINDOW_SIZE, 32'd1);
        write_reg(CFG_LANE_MASK, $urandom_range(255));
        write_reg(CFG_DC_REMOVE, 32'd1);
        write_reg(CFG_ENABLE, 32'd0);
        // ignored while disabled
        send_frame(1'b1, 1'b1, 0, 1'b0, n);
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        run_random(90);
        drain();

        // last setting: no idling at all, count mode never reaches its size
        send_idle = 0;
        recv_idle = 0;
        set_gen($urandom);
        write_reg(CFG_WINDOW_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_LANE_MASK, $urandom_range(255));
        write_reg(CFG_DC_REMOVE, $urandom_range(1));
        run_random(90);
        drain();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> windowed_mean_rms_meter.f
design/wmr_pkg.sv
design/wmr_ram.sv
design/wmr_mul.sv
design/wmr_div.sv
design/wmr_sqrt.sv
design/windowed_mean_rms_meter.sv
design/wmr_checker.sv
tb/tb_windowed_mean_rms_meter.sv
